/* sv/si2d_pkg.sv */
// shared widths, status codes and payload types for the segment intersection core
package si2d_pkg;
   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int PARAM_WIDTH = FRAC_BITS + 1;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;
   localparam int STATUS_WIDTH = 2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_MISS     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_HIT      = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_COLINEAR = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] p0_x;
      logic signed [COORD_WIDTH-1:0] p0_z;
      logic signed [COORD_WIDTH-1:0] p1_x;
      logic signed [COORD_WIDTH-1:0] p1_z;
      logic signed [COORD_WIDTH-1:0] q0_x;
      logic signed [COORD_WIDTH-1:0] q0_z;
      logic signed [COORD_WIDTH-1:0] q1_x;
      logic signed [COORD_WIDTH-1:0] q1_z;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]       status;
      logic signed [COORD_WIDTH-1:0] hit_x;
      logic signed [COORD_WIDTH-1:0] hit_z;
      logic [PARAM_WIDTH-1:0]        t_param;
      logic [PARAM_WIDTH-1:0]        u_param;
   } rsp_type;

   // one division step: shift remainder in, subtract when it fits
   typedef struct packed {
      logic [CROSS_WIDTH-1:0] rem;
      logic [PARAM_WIDTH-1:0] quo;
   } div_type;

   function automatic div_type div_step(div_type d, logic [CROSS_WIDTH-1:0] den);
      logic [CROSS_WIDTH:0] sh;
      div_type r;
      sh = {d.rem, 1'b0};
      r.quo = {d.quo[PARAM_WIDTH-2:0], 1'b0};
      r.rem = sh[CROSS_WIDTH-1:0];
      if (sh >= {1'b0, den}) begin
         r.rem = CROSS_WIDTH'(sh - {1'b0, den});
         r.quo[0] = 1'b1;
      end
      return r;
   endfunction
endpackage

/* sv/si2d_if.sv */
// valid/ready channel interfaces for requests and responses
interface si2d_req_if import si2d_pkg::*; (input logic clock);
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface si2d_rsp_if import si2d_pkg::*; (input logic clock);
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/si2d_cross.sv */
// front stages: differences, six products, determinant and cross terms with sign fold
module si2d_cross import si2d_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  req_type                       in_data,
   output logic                          out_valid,
   output logic [CROSS_WIDTH-1:0]        out_det,
   output logic [CROSS_WIDTH-1:0]        out_tn,
   output logic [CROSS_WIDTH-1:0]        out_un,
   output logic [STATUS_WIDTH-1:0]       out_status,
   output logic signed [COORD_WIDTH-1:0] out_p0_x,
   output logic signed [COORD_WIDTH-1:0] out_p0_z,
   output logic signed [DIFF_WIDTH-1:0]  out_ax,
   output logic signed [DIFF_WIDTH-1:0]  out_az
);
   // stage 1: differences
   logic v1_ff;
   logic signed [DIFF_WIDTH-1:0] ax_ff, az_ff, bx_ff, bz_ff, cx_ff, cz_ff;
   logic signed [COORD_WIDTH-1:0] p0x1_ff, p0z1_ff;
   // stage 2: products
   logic v2_ff;
   logic signed [PROD_WIDTH-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [DIFF_WIDTH-1:0] ax2_ff, az2_ff;
   logic signed [COORD_WIDTH-1:0] p0x2_ff, p0z2_ff;
   // stage 3: differences of products, fold sign
   logic v3_ff;
   logic signed [CROSS_WIDTH-1:0] det_in, tn_in, un_in;
   logic [CROSS_WIDTH-1:0] det_ff, tn_ff, un_ff;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic signed [DIFF_WIDTH-1:0] ax3_ff, az3_ff;
   logic signed [COORD_WIDTH-1:0] p0x3_ff, p0z3_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // sign folding and in-range test on exact cross terms
   always_comb begin
      logic signed [CROSS_WIDTH-1:0] d, t, u;
      d = CROSS_WIDTH'(m0_ff) - CROSS_WIDTH'(m1_ff);
      t = CROSS_WIDTH'(m2_ff) - CROSS_WIDTH'(m3_ff);
      u = CROSS_WIDTH'(m4_ff) - CROSS_WIDTH'(m5_ff);
      if (d < 0) begin
         d = -d;
         t = -t;
         u = -u;
      end
      det_in = d;
      tn_in = t;
      un_in = u;
      if (d == 0) begin
         status_in = (t == 0 && u == 0) ? STATUS_COLINEAR : STATUS_MISS;
      end else if (t >= 0 && t <= d && u >= 0 && u <= d) begin
         status_in = STATUS_HIT;
      end else begin
         status_in = STATUS_MISS;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= DIFF_WIDTH'(in_data.p1_x) - DIFF_WIDTH'(in_data.p0_x);
         az_ff <= DIFF_WIDTH'(in_data.p1_z) - DIFF_WIDTH'(in_data.p0_z);
         bx_ff <= DIFF_WIDTH'(in_data.q0_x) - DIFF_WIDTH'(in_data.q1_x);
         bz_ff <= DIFF_WIDTH'(in_data.q0_z) - DIFF_WIDTH'(in_data.q1_z);
         cx_ff <= DIFF_WIDTH'(in_data.q0_x) - DIFF_WIDTH'(in_data.p0_x);
         cz_ff <= DIFF_WIDTH'(in_data.q0_z) - DIFF_WIDTH'(in_data.p0_z);
         p0x1_ff <= in_data.p0_x;
         p0z1_ff <= in_data.p0_z;
         m0_ff <= ax_ff * bz_ff;
         m1_ff <= bx_ff * az_ff;
         m2_ff <= cx_ff * bz_ff;
         m3_ff <= bx_ff * cz_ff;
         m4_ff <= ax_ff * cz_ff;
         m5_ff <= cx_ff * az_ff;
         ax2_ff <= ax_ff;
         az2_ff <= az_ff;
         p0x2_ff <= p0x1_ff;
         p0z2_ff <= p0z1_ff;
         det_ff <= det_in;
         tn_ff <= tn_in;
         un_ff <= un_in;
         status_ff <= status_in;
         ax3_ff <= ax2_ff;
         az3_ff <= az2_ff;
         p0x3_ff <= p0x2_ff;
         p0z3_ff <= p0z2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_det    = det_ff;
   assign out_tn     = tn_ff;
   assign out_un     = un_ff;
   assign out_status = status_ff;
   assign out_p0_x   = p0x3_ff;
   assign out_p0_z   = p0z3_ff;
   assign out_ax     = ax3_ff;
   assign out_az     = az3_ff;
endmodule

/* sv/si2d_divide.sv */
// pipelined restoring divider for t and u, one quotient bit per stage
module si2d_divide import si2d_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [CROSS_WIDTH-1:0]        in_det,
   input  logic [CROSS_WIDTH-1:0]        in_tn,
   input  logic [CROSS_WIDTH-1:0]        in_un,
   input  logic [STATUS_WIDTH-1:0]       in_status,
   input  logic signed [COORD_WIDTH-1:0] in_p0_x,
   input  logic signed [COORD_WIDTH-1:0] in_p0_z,
   input  logic signed [DIFF_WIDTH-1:0]  in_ax,
   input  logic signed [DIFF_WIDTH-1:0]  in_az,
   output logic                          out_valid,
   output logic [PARAM_WIDTH-1:0]        out_tq,
   output logic [PARAM_WIDTH-1:0]        out_uq,
   output logic [STATUS_WIDTH-1:0]       out_status,
   output logic signed [COORD_WIDTH-1:0] out_p0_x,
   output logic signed [COORD_WIDTH-1:0] out_p0_z,
   output logic signed [DIFF_WIDTH-1:0]  out_ax,
   output logic signed [DIFF_WIDTH-1:0]  out_az
);
   localparam int NST = FRAC_BITS + 1;

   logic [NST-1:0] v_ff;
   div_type t_ff [NST];
   div_type u_ff [NST];
   logic [CROSS_WIDTH-1:0] den_ff [NST];
   logic [STATUS_WIDTH-1:0] st_ff [NST];
   logic signed [COORD_WIDTH-1:0] px_ff [NST];
   logic signed [COORD_WIDTH-1:0] pz_ff [NST];
   logic signed [DIFF_WIDTH-1:0] ax_ff [NST];
   logic signed [DIFF_WIDTH-1:0] az_ff [NST];
   div_type t0_in, u0_in;

   // first quotient bit: integer part, at most one for a hit, where num <= den
   always_comb begin
      t0_in.rem = in_tn;
      t0_in.quo = '0;
      u0_in.rem = in_un;
      u0_in.quo = '0;
      if (in_tn >= in_det) begin
         t0_in.rem = in_tn - in_det;
         t0_in.quo = PARAM_WIDTH'(1);
      end
      if (in_un >= in_det) begin
         u0_in.rem = in_un - in_det;
         u0_in.quo = PARAM_WIDTH'(1);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0] <= t0_in;
         u_ff[0] <= u0_in;
         den_ff[0] <= in_det;
         st_ff[0] <= in_status;
         px_ff[0] <= in_p0_x;
         pz_ff[0] <= in_p0_z;
         ax_ff[0] <= in_ax;
         az_ff[0] <= in_az;
         for (int i = 1; i < NST; i++) begin
            t_ff[i] <= div_step(t_ff[i-1], den_ff[i-1]);
            u_ff[i] <= div_step(u_ff[i-1], den_ff[i-1]);
            den_ff[i] <= den_ff[i-1];
            st_ff[i] <= st_ff[i-1];
            px_ff[i] <= px_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
            ax_ff[i] <= ax_ff[i-1];
            az_ff[i] <= az_ff[i-1];
         end
      end
   end

   assign out_valid  = v_ff[NST-1];
   assign out_tq     = t_ff[NST-1].quo;
   assign out_uq     = u_ff[NST-1].quo;
   assign out_status = st_ff[NST-1];
   assign out_p0_x   = px_ff[NST-1];
   assign out_p0_z   = pz_ff[NST-1];
   assign out_ax     = ax_ff[NST-1];
   assign out_az     = az_ff[NST-1];
endmodule

/* sv/si2d_point.sv */
// back stages: scale delta by t, form the point, zero fields unless the status is a hit
module si2d_point import si2d_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [PARAM_WIDTH-1:0]        in_tq,
   input  logic [PARAM_WIDTH-1:0]        in_uq,
   input  logic [STATUS_WIDTH-1:0]       in_status,
   input  logic signed [COORD_WIDTH-1:0] in_p0_x,
   input  logic signed [COORD_WIDTH-1:0] in_p0_z,
   input  logic signed [DIFF_WIDTH-1:0]  in_ax,
   input  logic signed [DIFF_WIDTH-1:0]  in_az,
   output logic                          out_valid,
   output rsp_type                       out_data
);
   localparam int MW = PARAM_WIDTH + 1 + DIFF_WIDTH;

   logic v1_ff, v2_ff;
   logic signed [MW-1:0] mx_ff, mz_ff;
   logic [PARAM_WIDTH-1:0] tq_ff, uq_ff;
   logic [STATUS_WIDTH-1:0] st_ff;
   logic signed [COORD_WIDTH-1:0] px_ff, pz_ff;
   logic signed [MW-1:0] sx, sz;
   logic hit;
   rsp_type res_ff, res_in;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // shift, add, and mask result fields
   always_comb begin
      sx = mx_ff >>> FRAC_BITS;
      sz = mz_ff >>> FRAC_BITS;
      hit = (st_ff == STATUS_HIT);
      res_in.status  = st_ff;
      res_in.hit_x   = hit ? COORD_WIDTH'(px_ff + sx[COORD_WIDTH-1:0]) : '0;
      res_in.hit_z   = hit ? COORD_WIDTH'(pz_ff + sz[COORD_WIDTH-1:0]) : '0;
      res_in.t_param = hit ? tq_ff : '0;
      res_in.u_param = hit ? uq_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= $signed({1'b0, in_tq}) * in_ax;
         mz_ff <= $signed({1'b0, in_tq}) * in_az;
         tq_ff <= in_tq;
         uq_ff <= in_uq;
         st_ff <= in_status;
         px_ff <= in_p0_x;
         pz_ff <= in_p0_z;
         res_ff <= res_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = res_ff;
endmodule

/* sv/segment_intersect_2d_core.sv */
// top level of the 2d segment intersection pipeline
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | two segments, signed Q8.8 end points
//  rsp     | out | rsp_valid/rsp_ready  | status, hit point, t and u
// one pair accepted per cycle unless stalled; the pipeline has 3 cross-product stages,
// 17 divider stages, one quotient bit each, 2 point stages, 1 output queue register
// reset clears all valid bits; payload registers are not reset
// the whole pipeline advances together; it stalls only when the output queue holds
// two results and the head is not taken
module segment_intersect_2d_core import si2d_pkg::*; (
   input logic       clock,
   input logic       reset,
   si2d_req_if.sink  req,
   si2d_rsp_if.source rsp
);
   logic adv;
   logic cv, dv, pv;
   logic [CROSS_WIDTH-1:0] c_det, c_tn, c_un;
   logic [STATUS_WIDTH-1:0] c_st, d_st;
   logic signed [COORD_WIDTH-1:0] c_px, c_pz, d_px, d_pz;
   logic signed [DIFF_WIDTH-1:0] c_ax, c_az, d_ax, d_az;
   logic [PARAM_WIDTH-1:0] d_tq, d_uq;
   rsp_type p_data;

   // two-entry skid queue at the output
   rsp_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign adv = (cnt_ff != 2'd2) || pop;
   // advance whenever the pipe output can be stored
   assign req.ready = adv;
   assign push = adv && pv;
   assign pop  = rsp.valid && rsp.ready;

   si2d_cross u_cross (
      .clock, .reset, .adv,
      .in_valid(req.valid && req.ready), .in_data(req.data),
      .out_valid(cv), .out_det(c_det), .out_tn(c_tn), .out_un(c_un),
      .out_status(c_st), .out_p0_x(c_px), .out_p0_z(c_pz),
      .out_ax(c_ax), .out_az(c_az)
   );

   si2d_divide u_divide (
      .clock, .reset, .adv,
      .in_valid(cv), .in_det(c_det), .in_tn(c_tn), .in_un(c_un),
      .in_status(c_st), .in_p0_x(c_px), .in_p0_z(c_pz), .in_ax(c_ax), .in_az(c_az),
      .out_valid(dv), .out_tq(d_tq), .out_uq(d_uq), .out_status(d_st),
      .out_p0_x(d_px), .out_p0_z(d_pz), .out_ax(d_ax), .out_az(d_az)
   );

   si2d_point u_point (
      .clock, .reset, .adv,
      .in_valid(dv), .in_tq(d_tq), .in_uq(d_uq), .in_status(d_st),
      .in_p0_x(d_px), .in_p0_z(d_pz), .in_ax(d_ax), .in_az(d_az),
      .out_valid(pv), .out_data(p_data)
   );

   // queue count
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // queue storage, head at slot 0
   always_ff @(posedge clock) begin
      priority if (pop && push && cnt_ff == 2'd1) begin
         q_ff[0] <= p_data;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
         if (push) q_ff[1] <= p_data;
      end else if (push) begin
         if (cnt_ff == 2'd0) q_ff[0] <= p_data;
         else q_ff[1] <= p_data;
      end
   end

   assign rsp.valid = (cnt_ff != 2'd0);
   assign rsp.data  = q_ff[0];

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("skid count overflow");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      pv && !adv |=> pv)
      else $error("pipe output lost on stall");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !rsp.ready |-> !req.ready)
      else $error("accepted while queue full");
   a_params_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.status != STATUS_HIT |->
      rsp.data.t_param == '0 && rsp.data.u_param == '0)
      else $error("parameters set on miss");
endmodule
